// File: sv/palette_nearest_colour_match_top_macros.svh
// assertion helpers for the palette matcher
`ifndef PALETTE_NEAREST_COLOUR_MATCH_TOP_MACROS_SVH
`define PALETTE_NEAREST_COLOUR_MATCH_TOP_MACROS_SVH
`define PNCM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pncm check failed");
`define PNCM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pncm check failed");
`endif

// File: sv/pncm_pkg.sv
package pncm_pkg;
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_MATCH = 2'd2;
    localparam logic signed [3:0] AGE_MAX  = 4'sd5;
    localparam logic signed [3:0] AGE_IDLE = -4'sd1;
    localparam logic [10:0] DIST_INIT = 11'd1023;

    // one cache cell's view, for the fill victim scan
    typedef struct packed {
        logic       valid;
        logic       hit;
        logic signed [3:0] age;
    } t_cell_stat;

    function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction
endpackage

// File: sv/palette_nearest_colour_match_top.sv
// palette nearest colour matcher with a small lru match cache
// input beat: i_cmd, i_entry_index, i_colour on i_valid/o_ready; one result
// beat per input on o_valid/i_ready with match, read and status fields
// i_cfg_we writes palette_size (takes effect at once, clears the cache)
// write and read: the beat passes ST_RD, ST_RDW and ST_OUT before the result (palette ram has a registered read)
// match: the cache ages as the beat is taken, then the hit and fill victim are
// found by a sequential scan across the cells, one cell per cycle; a hit then goes
// through ST_FILL and ST_OUT to its result, while a miss first walks the palette
// ram, one distance per cycle, and then goes through ST_FILL and ST_OUT; one
// item at a time
// reset (synchronous, i_rst_n low) clears the cache, sets palette_size to 256
// and then sweeps all MAX_ENTRIES palette ram entries to zero, with o_ready
// low; o_valid holds its result until i_ready, no new item is taken then
module palette_nearest_colour_match_top import pncm_pkg::*; #(
    parameter int MAX_ENTRIES   = 256,
    parameter int CACHE_ENTRIES = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_entry_index,
    input  logic [23:0] i_colour,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_match_index,
    output logic        o_match_found,
    output logic        o_cache_hit,
    output logic [23:0] o_read_colour,
    output logic        o_status,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int SW = AW + 1;
    localparam int LIM = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_WALK = 3'd4;
    localparam logic [2:0] ST_FILL = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;
    localparam logic [2:0] ST_RDW  = 3'd7;

    logic [2:0]  r_state;
    logic [8:0]  r_size;
    logic [1:0]  r_cmd;
    logic [7:0]  r_idx;
    logic [23:0] r_col;
    logic [AW:0] r_cnt;
    logic [CW:0] r_ci;
    logic        r_hit_found;
    logic [8:0]  r_res;
    logic [CW-1:0] r_hit_slot;
    logic        r_vic_done;
    logic [CW-1:0] r_vic;
    logic signed [3:0] r_low;
    logic [10:0] r_best;
    logic [AW:0] r_pidx;
    logic        r_pv;
    logic        r_ovalid;
    logic [7:0]  r_mi;
    logic        r_mf, r_ch, r_st;
    logic [23:0] r_rc;

    logic [SW-1:0] eff;
    assign eff = (r_size > 9'(LIM)) ? SW'(LIM) : SW'(r_size);

    logic in_go;
    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign in_go   = i_valid && o_ready;

    // palette ram
    logic          ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [23:0]   ram_wd, ram_rd;
    logic          idx_ok;
    assign idx_ok = {1'b0, r_idx} < 9'(eff);
    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_cnt[AW-1:0];
        ram_wd = '0;
        if (r_state == ST_CLR) begin
            ram_we = 1'b1;
        end else if (r_state == ST_RD && r_cmd == CMD_WRITE && idx_ok) begin
            ram_we = 1'b1;
            ram_wa = AW'(r_idx);
            ram_wd = r_col;
        end
        ram_ra = (r_state == ST_WALK) ? r_cnt[AW-1:0] : AW'(r_idx);
    end
    pncm_ram #(.WIDTH(24), .DEPTH(MAX_ENTRIES)) u_pal (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    // cache cell row
    t_cell_stat stat [CACHE_ENTRIES];
    logic [8:0] cres [CACHE_ENTRIES];
    logic       age_now;
    assign age_now = in_go && i_cmd == CMD_MATCH;
    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        pncm_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(i_cfg_we),
            .i_age(age_now), .i_colour(r_col),
            .i_hit_take(r_state == ST_FILL && r_hit_found && r_hit_slot == CW'(g)),
            .i_fill(r_state == ST_FILL && !r_hit_found && r_vic == CW'(g)),
            .i_fill_res(r_res), .o_stat(stat[g]), .o_res(cres[g])
        );
    end

    t_cell_stat cur;
    logic [8:0] cur_res;
    logic [CW-1:0] ci;
    assign ci      = r_ci[CW-1:0];
    assign cur     = stat[ci];
    assign cur_res = cres[ci];

    logic [10:0] pdist;
    assign pdist = 11'(absd(r_col[23:16], ram_rd[23:16]))
                 + 11'(absd(r_col[15:8], ram_rd[15:8]))
                 + 11'(absd(r_col[7:0], ram_rd[7:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_cnt    <= '0;
            r_size   <= 9'd256;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (AW+1)'(MAX_ENTRIES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_go) begin
                        r_cmd <= i_cmd;
                        r_idx <= i_entry_index;
                        r_col <= i_colour;
                        r_ci  <= '0;
                        r_hit_found <= 1'b0;
                        r_vic_done  <= 1'b0;
                        r_vic <= '0;
                        r_state <= (i_cmd == CMD_MATCH) ? ST_SCAN : ST_RD;
                    end
                end
                ST_RD: r_state <= ST_RDW;
                ST_RDW: begin
                    r_mi <= '0; r_mf <= 1'b0; r_ch <= 1'b0;
                    r_rc <= '0; r_st <= 1'b0;
                    if (r_cmd == CMD_WRITE || r_cmd == CMD_READ) begin
                        r_st <= !idx_ok;
                        if (r_cmd == CMD_READ && idx_ok) begin
                            r_rc <= ram_rd;
                        end
                    end
                    r_state <= ST_OUT;
                end
                ST_SCAN: begin
                    if (cur.hit && !r_hit_found) begin
                        r_hit_found <= 1'b1;
                        r_hit_slot  <= ci;
                        r_res       <= cur_res;
                    end
                    if (!r_vic_done) begin
                        if (cur.age < 0) begin
                            r_vic <= ci; r_vic_done <= 1'b1;
                        end else if (r_ci == '0 || cur.age < r_low) begin
                            r_vic <= ci; r_low <= cur.age;
                        end
                    end
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == (CW+1)'(CACHE_ENTRIES - 1)) begin
                        if (r_hit_found || cur.hit) begin
                            r_state <= ST_FILL;
                        end else begin
                            r_state <= ST_WALK;
                            r_cnt   <= '0;
                            r_pv    <= 1'b0;
                            r_best  <= DIST_INIT;
                            r_res   <= 9'h100;
                        end
                    end
                end
                ST_WALK: begin
                    // address issued this cycle, data next cycle
                    if (r_pv && pdist < r_best) begin
                        r_best <= pdist;
                        r_res  <= {1'b0, 8'(r_pidx)};
                    end
                    r_pidx <= r_cnt;
                    r_pv   <= (r_cnt < (AW+1)'(eff));
                    r_cnt  <= r_cnt + 1'b1;
                    if (!(r_cnt < (AW+1)'(eff)) && !r_pv || r_cnt == (AW+1)'(MAX_ENTRIES)) begin
                        r_state <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    r_mf <= !r_res[8];
                    r_mi <= r_res[8] ? 8'd0 : r_res[7:0];
                    r_ch <= r_hit_found;
                    r_rc <= '0; r_st <= 1'b0;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_match_index = r_mi;
    assign o_match_found = r_mf;
    assign o_cache_hit   = r_ch;
    assign o_read_colour = r_rc;
    assign o_status      = r_st;
endmodule

// File: sv/pncm_ram.sv
module pncm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: sv/pncm_cell.sv
// one cache cell: colour, result, age, valid
module pncm_cell import pncm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_age,
    input  logic [23:0] i_colour,
    input  logic        i_hit_take,
    input  logic        i_fill,
    input  logic [8:0]  i_fill_res,
    output t_cell_stat  o_stat,
    output logic [8:0]  o_res
);
    logic        r_valid;
    logic signed [3:0] r_age;
    logic [23:0] r_colour;
    logic [8:0]  r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
            r_age   <= AGE_IDLE;
        end else if (i_fill) begin
            r_valid <= 1'b1;
            r_age   <= AGE_MAX;
        end else if (i_hit_take) begin
            r_age <= AGE_MAX;
        end else if (i_age && r_age != AGE_IDLE) begin
            r_age <= r_age - 4'sd1;
        end
        if (i_fill) begin
            r_colour <= i_colour;
            r_res    <= i_fill_res;
        end
    end

    assign o_stat.valid = r_valid;
    assign o_stat.hit   = r_valid && (r_colour == i_colour);
    assign o_stat.age   = r_age;
    assign o_res        = r_res;
endmodule

// File: sv/pncm_checker.sv
`include "palette_nearest_colour_match_top_macros.svh"
module pncm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_match_found,
    input logic        o_cache_hit,
    input logic [7:0]  o_match_index,
    input logic [23:0] o_read_colour,
    input logic        o_status
);
    `PNCM_ASSERT_IMP(a_busy, i_clk, i_rst_n, o_valid, !o_ready)
    `PNCM_ASSERT_IMP(a_hit_found, i_clk, i_rst_n, o_valid && o_cache_hit && !o_match_found, o_match_index == 8'd0)
    `PNCM_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid && o_match_found, o_read_colour == 24'd0 && !o_status)
    `PNCM_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_match_index))
endmodule

bind palette_nearest_colour_match_top pncm_checker u_pncm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_match_found(o_match_found),
    .o_cache_hit(o_cache_hit), .o_match_index(o_match_index),
    .o_read_colour(o_read_colour), .o_status(o_status)
);
